[design/stt_pkg.sv]
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types, codes and constants of the software timer table.
// ----------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

  localparam int unsigned DEF_POOL_SLOTS = 16;
  localparam int unsigned MAX_RESULTS    = 16;
  localparam int unsigned EV_CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int unsigned EV_IDX_W       = $clog2(MAX_RESULTS);
  localparam int unsigned FREE_W         = 7;
  localparam int unsigned IN_DATA_W      = 88;
  localparam int unsigned OUT_DATA_W     = 32;

  typedef enum logic [1:0] {
    OP_SET    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_TICK   = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_EXPIRY = 1'b1;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
    logic insert;
    logic emit_status;
    logic emit_event;
  } cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    scan_done;
    logic    found;
    logic    full;
    logic    ev_any;
    logic    ev_last;
    logic    out_free;
  } stat_t;

endpackage

`default_nettype wire

[design/stt_ctrl.sv]
// ----------------------------------------------------------------------------
// stt_ctrl
// Sequencer of the timer table: accept, scan, insert and result drain.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  input  wire logic [1:0]    in_op,
  output logic               in_tready,
  input  wire stt_pkg::stat_t st,
  output stt_pkg::cmd_t      cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_INS   = 5'b00100,
    S_STAT  = 5'b01000,
    S_DRAIN = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load = 1'b1;
          if (in_op != stt_pkg::OP_NONE) state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (st.scan_done) begin
          cmd.finish = 1'b1;
          if (st.op == stt_pkg::OP_TICK) begin
            state_nxt = st.ev_any ? S_DRAIN : S_IDLE;
          end else if (st.op == stt_pkg::OP_SET && !st.found && !st.full) begin
            state_nxt = S_INS;
          end else begin
            state_nxt = S_STAT;
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_INS: begin
        cmd.insert = 1'b1;
        state_nxt  = S_STAT;
      end
      S_STAT: begin
        if (st.out_free) begin
          cmd.emit_status = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_DRAIN: begin
        if (st.out_free) begin
          cmd.emit_event = 1'b1;
          if (st.ev_last) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS) |=> (state_r == S_STAT))
    else $error("insert not followed by status");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (state_r == S_IDLE))
    else $error("item taken while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && st.scan_done && st.op == stt_pkg::OP_TICK && !st.ev_any)
      |=> (state_r == S_IDLE))
    else $error("silent tick did not end");

endmodule

`default_nettype wire

[design/stt_dp.sv]
// ----------------------------------------------------------------------------
// stt_dp
// Timer slot storage, order list, expiry buffer and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_dp #(
  parameter int unsigned POOL_SLOTS = stt_pkg::DEF_POOL_SLOTS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire stt_pkg::cmd_t         cmd,
  output stt_pkg::stat_t             st,
  input  wire logic [1:0]            in_op,
  input  wire logic [7:0]            in_task,
  input  wire logic [7:0]            in_sig,
  input  wire logic [31:0]           in_dur,
  input  wire logic                  in_per,
  input  wire logic [31:0]           in_el,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_kind,
  output logic [1:0]                 out_status,
  output logic [7:0]                 out_task,
  output logic [7:0]                 out_sig,
  output logic [stt_pkg::FREE_W-1:0] out_free,
  output logic                       out_last
);

  localparam int unsigned IDX_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(POOL_SLOTS + 1);
  localparam logic [CNT_W-1:0] POOL_CNT = CNT_W'(POOL_SLOTS);

  logic [7:0]            task_r   [POOL_SLOTS];
  logic [7:0]            sig_r    [POOL_SLOTS];
  logic [31:0]           count_r  [POOL_SLOTS];
  logic [31:0]           period_r [POOL_SLOTS];
  logic [IDX_W-1:0]      order_r  [POOL_SLOTS];
  logic [POOL_SLOTS-1:0] free_r;
  logic [CNT_W-1:0]      act_r;

  stt_pkg::opcode_t op_r;
  logic [7:0]       key_task_r, key_sig_r;
  logic [31:0]      dur_r, el_r;
  logic             per_r;
  logic [CNT_W-1:0] i_r, wr_r;
  logic             found_r;
  logic [1:0]       status_r;

  logic [7:0]                 ev_task_r [stt_pkg::MAX_RESULTS];
  logic [7:0]                 ev_sig_r  [stt_pkg::MAX_RESULTS];
  logic [stt_pkg::EV_CNT_W-1:0] ev_n_r, rd_r;

  logic                       out_valid_r, out_kind_r, out_last_r;
  logic [1:0]                 out_status_r;
  logic [7:0]                 out_task_r, out_sig_r;
  logic [stt_pkg::FREE_W-1:0] out_free_r;

  logic [IDX_W-1:0] cur_s, ins_s;
  logic             hit, expired;
  logic [31:0]      cur_cnt, sub_cnt;
  logic             can_load;

  assign cur_s   = order_r[i_r[IDX_W-1:0]];
  assign hit     = (task_r[cur_s] == key_task_r) && (sig_r[cur_s] == key_sig_r);
  assign cur_cnt = count_r[cur_s];
  assign sub_cnt = (cur_cnt > el_r) ? (cur_cnt - el_r) : 32'd0;
  assign expired = (sub_cnt == 32'd0);
  assign can_load = !out_valid_r || out_ready;

  always_comb begin
    ins_s = '0;
    for (int j = POOL_SLOTS - 1; j >= 0; j--) begin
      if (free_r[j]) ins_s = IDX_W'(j);
    end
  end

  assign st.op        = op_r;
  assign st.scan_done = (i_r == act_r) || (op_r == stt_pkg::OP_SET && found_r);
  assign st.found     = found_r;
  assign st.full      = (act_r == POOL_CNT);
  assign st.ev_any    = (ev_n_r != '0);
  assign st.ev_last   = (rd_r == ev_n_r - stt_pkg::EV_CNT_W'(1));
  assign st.out_free  = can_load;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r       <= stt_pkg::opcode_t'(in_op);
      key_task_r <= in_task;
      key_sig_r  <= in_sig;
      dur_r      <= in_dur;
      per_r      <= in_per;
      el_r       <= in_el;
    end
    if (cmd.step) begin
      case (op_r)
        stt_pkg::OP_SET: begin
          if (hit) count_r[cur_s] <= dur_r;
        end
        stt_pkg::OP_REMOVE: begin
          if (!(hit && !found_r)) order_r[wr_r[IDX_W-1:0]] <= cur_s;
        end
        stt_pkg::OP_TICK: begin
          if (expired) begin
            if (stt_pkg::EV_CNT_W'(ev_n_r) < stt_pkg::EV_CNT_W'(stt_pkg::MAX_RESULTS)) begin
              ev_task_r[ev_n_r[stt_pkg::EV_IDX_W-1:0]] <= task_r[cur_s];
              ev_sig_r[ev_n_r[stt_pkg::EV_IDX_W-1:0]]  <= sig_r[cur_s];
            end
            count_r[cur_s] <= period_r[cur_s];
            if (period_r[cur_s] != 32'd0) order_r[wr_r[IDX_W-1:0]] <= cur_s;
          end else begin
            count_r[cur_s]             <= sub_cnt;
            order_r[wr_r[IDX_W-1:0]] <= cur_s;
          end
        end
        default: ;
      endcase
    end
    if (cmd.insert) begin
      task_r[ins_s]   <= key_task_r;
      sig_r[ins_s]    <= key_sig_r;
      count_r[ins_s]  <= dur_r;
      period_r[ins_s] <= per_r ? dur_r : 32'd0;
      for (int j = 1; j < POOL_SLOTS; j++) order_r[j] <= order_r[j-1];
      order_r[0] <= ins_s;
    end
    if (cmd.finish) begin
      if (op_r == stt_pkg::OP_SET) begin
        status_r <= (found_r || act_r != POOL_CNT) ? stt_pkg::ST_OK : stt_pkg::ST_FULL;
      end else begin
        status_r <= found_r ? stt_pkg::ST_OK : stt_pkg::ST_NOT_FOUND;
      end
    end
    if (can_load) begin
      out_kind_r   <= cmd.emit_event ? stt_pkg::KIND_EXPIRY : stt_pkg::KIND_STATUS;
      out_status_r <= cmd.emit_event ? stt_pkg::ST_OK : status_r;
      out_task_r   <= cmd.emit_event ? ev_task_r[rd_r[stt_pkg::EV_IDX_W-1:0]] : 8'd0;
      out_sig_r    <= cmd.emit_event ? ev_sig_r[rd_r[stt_pkg::EV_IDX_W-1:0]] : 8'd0;
      out_free_r   <= stt_pkg::FREE_W'(POOL_CNT - act_r);
      out_last_r   <= cmd.emit_event ? st.ev_last : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= '0;
      free_r      <= '1;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      wr_r        <= '0;
      found_r     <= 1'b0;
      ev_n_r      <= '0;
      rd_r        <= '0;
    end else begin
      if (cmd.load) begin
        i_r     <= '0;
        wr_r    <= '0;
        found_r <= 1'b0;
        ev_n_r  <= '0;
        rd_r    <= '0;
      end
      if (cmd.step) begin
        i_r <= i_r + CNT_W'(1);
        case (op_r)
          stt_pkg::OP_SET: begin
            if (hit) found_r <= 1'b1;
          end
          stt_pkg::OP_REMOVE: begin
            if (hit && !found_r) begin
              found_r       <= 1'b1;
              free_r[cur_s] <= 1'b1;
            end else begin
              wr_r <= wr_r + CNT_W'(1);
            end
          end
          stt_pkg::OP_TICK: begin
            if (expired) begin
              if (ev_n_r < stt_pkg::EV_CNT_W'(stt_pkg::MAX_RESULTS)) begin
                ev_n_r <= ev_n_r + stt_pkg::EV_CNT_W'(1);
              end
              if (period_r[cur_s] != 32'd0) wr_r <= wr_r + CNT_W'(1);
              else free_r[cur_s] <= 1'b1;
            end else begin
              wr_r <= wr_r + CNT_W'(1);
            end
          end
          default: ;
        endcase
      end
      if (cmd.finish && op_r != stt_pkg::OP_SET) act_r <= wr_r;
      if (cmd.insert) begin
        free_r[ins_s] <= 1'b0;
        act_r         <= act_r + CNT_W'(1);
      end
      if (cmd.emit_event) rd_r <= rd_r + stt_pkg::EV_CNT_W'(1);
      if (cmd.emit_status || cmd.emit_event) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_kind   = out_kind_r;
  assign out_status = out_status_r;
  assign out_task   = out_task_r;
  assign out_sig    = out_sig_r;
  assign out_free   = out_free_r;
  assign out_last   = out_last_r;

  assert property (@(posedge clk) disable iff (!rst_n) act_r <= POOL_CNT)
    else $error("active count above pool size");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_event |-> (ev_n_r != '0) && (rd_r < ev_n_r))
    else $error("expiry read past buffer");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert |-> free_r[ins_s] && (act_r < POOL_CNT))
    else $error("insert without free slot");

endmodule

`default_nettype wire

[design/software_timer_table.sv]
// ----------------------------------------------------------------------------
// software_timer_table
// Pool of keyed one-shot and periodic timers with set, remove and tick.
// ----------------------------------------------------------------------------
// Channel  Direction  tdata fields (low bit up)                      tuser   tlast
// in_      input      task_id, signal, duration, periodic, elapsed   opcode  -
// out_     output     status, expired_task, expired_signal, free     kind    last
//
// One word is taken at a time. An item passes through an accept, a scan of
// the active timer list (a set stops at its matching key), the scan end, an
// insert into a free slot for a new set, and then its result words.
// Reset clears the pool at once; slot contents are not cleared.
// A stalled out_tready holds the current word; the sequencer waits before it emits the next.
// ----------------------------------------------------------------------------
`default_nettype none

module software_timer_table #(
  parameter int unsigned POOL_SLOTS = stt_pkg::DEF_POOL_SLOTS
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [stt_pkg::IN_DATA_W-1:0]    in_tdata,  // task_id, signal, duration, periodic, elapsed_ticks
  input  wire logic [1:0]                       in_tuser,  // opcode
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [stt_pkg::OUT_DATA_W-1:0]        out_tdata, // status, expired_task, expired_signal, free_slots
  output logic                                  out_tuser, // kind
  output logic                                  out_tlast
);

  stt_pkg::cmd_t  cmd;
  stt_pkg::stat_t st;

  logic [1:0]                 o_status;
  logic [7:0]                 o_task, o_sig;
  logic [stt_pkg::FREE_W-1:0] o_free;

  stt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_op     (in_tuser),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  stt_dp #(
    .POOL_SLOTS (POOL_SLOTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .in_op      (in_tuser),
    .in_task    (in_tdata[7:0]),
    .in_sig     (in_tdata[15:8]),
    .in_dur     (in_tdata[47:16]),
    .in_per     (in_tdata[48]),
    .in_el      (in_tdata[80:49]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_kind   (out_tuser),
    .out_status (o_status),
    .out_task   (o_task),
    .out_sig    (o_sig),
    .out_free   (o_free),
    .out_last   (out_tlast)
  );

  assign out_tdata = {7'd0, o_free, o_sig, o_task, o_status};

endmodule

`default_nettype wire
